[hdl/amh_pkg.sv]
// Package: shared types, constants and AES helper functions for the MMO hash unit.
package amh_pkg;

  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned FILL_W      = 4;
  localparam int unsigned ROUND_W     = 4;
  localparam int unsigned NUM_ROUNDS  = 10;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [FILL_W-1:0] LEN_POS = 4'd14;

  typedef logic [127:0] blk_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic put_byte;     // write data byte at fill position
    logic pad;          // write 0x80 and clear the tail
    logic put_len;      // write the bit length into bytes 14-15
    logic aes_start;    // load state and round key for a new block
    logic aes_round;    // run one round
    logic chain_update; // chain <= aes ^ block, clear block
    logic clear_all;    // return to reset values
  } amh_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic block_full;   // fill count wraps on this byte
    logic pad_extra;    // 13 or more bytes held before padding
  } amh_sts_t;

  typedef logic [7:0] sbox_t [256];

  localparam sbox_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block, byte 0 in the top bits.
  function automatic logic [7:0] get_b(input blk_t v, input int i);
    get_b = v[127 - 8*i -: 8];
  endfunction

endpackage

[hdl/amh_if.sv]
// Interface: valid/ready channel carrying a generic payload.
interface amh_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hdl/amh_datapath.sv]
// Datapath: block buffer, length count, chain register and round-iterative AES-128.
module amh_datapath (
  input  logic            clk,
  input  logic            rst,
  input  amh_pkg::amh_cmd_t cmd,
  input  logic [7:0]      data_byte,
  output amh_pkg::amh_sts_t sts,
  output amh_pkg::blk_t   chain
);
  import amh_pkg::*;

  blk_t            block;
  blk_t            state;
  blk_t            rkey;
  logic [7:0]      rcon;
  logic [ROUND_W-1:0] round;
  logic [FILL_W-1:0]  fill;
  logic [LEN_W-1:0]   msg_len;

  blk_t block_next;
  blk_t rk_next;
  blk_t sr;
  blk_t mc;
  blk_t rnd_out;
  logic [15:0] bits;

  assign sts.block_full = (fill == 4'd15);
  assign sts.pad_extra  = (fill >= 4'd13);
  assign bits = {msg_len, 3'b000};

  // Round key expansion.
  always_comb begin
    logic [31:0] t;
    t = {SBOX[get_b(rkey,13)] ^ rcon, SBOX[get_b(rkey,14)],
         SBOX[get_b(rkey,15)], SBOX[get_b(rkey,12)]};
    rk_next[127:96] = rkey[127:96] ^ t;
    rk_next[95:64]  = rkey[95:64] ^ rk_next[127:96];
    rk_next[63:32]  = rkey[63:32] ^ rk_next[95:64];
    rk_next[31:0]   = rkey[31:0] ^ rk_next[63:32];
  end

  // SubBytes, ShiftRows, MixColumns (not in the last round) and AddRoundKey.
  always_comb begin
    logic [7:0] a0, a1, a2, a3, t;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[127 - 8*(i+4*c) -: 8] = SBOX[get_b(state, i + 4*((c+i) & 3))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(sr, 4*c);   a1 = get_b(sr, 4*c+1);
      a2 = get_b(sr, 4*c+2); a3 = get_b(sr, 4*c+3);
      t  = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 8*(4*c)   -: 8] = a0 ^ t ^ xt(a0 ^ a1);
      mc[127 - 8*(4*c+1) -: 8] = a1 ^ t ^ xt(a1 ^ a2);
      mc[127 - 8*(4*c+2) -: 8] = a2 ^ t ^ xt(a2 ^ a3);
      mc[127 - 8*(4*c+3) -: 8] = a3 ^ t ^ xt(a3 ^ a0);
    end
    rnd_out = ((round == ROUND_W'(NUM_ROUNDS)) ? sr : mc) ^ rk_next;
  end

  always_comb begin
    block_next = block;
    if (cmd.put_byte) begin
      block_next[127 - 8*fill -: 8] = data_byte;
    end
    if (cmd.pad) begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        if (i == int'(fill)) block_next[127 - 8*i -: 8] = PAD_BYTE;
        else if (i > int'(fill)) block_next[127 - 8*i -: 8] = 8'h00;
      end
    end
    if (cmd.put_len) begin
      block_next[15:0] = bits;
    end
    // Clear the buffer once its block has been folded into the chain.
    if (cmd.chain_update) begin
      block_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      block   <= '0;
      chain   <= '0;
      fill    <= '0;
      msg_len <= '0;
      round   <= '0;
      rcon    <= 8'h01;
    end else begin
      block <= block_next;
      if (cmd.put_byte) begin
        fill    <= fill + 4'd1;
        msg_len <= msg_len + LEN_W'(1);
      end
      if (cmd.aes_start) begin
        state <= block ^ chain;
        rkey  <= chain;
        round <= 4'd1;
        rcon  <= 8'h01;
      end else if (cmd.aes_round) begin
        state <= rnd_out;
        rkey  <= rk_next;
        rcon  <= xt(rcon);
        round <= round + 4'd1;
      end
      if (cmd.chain_update) begin
        chain <= state ^ block;
      end
    end
  end

endmodule

[hdl/amh_ctrl.sv]
// Controller: sequences byte intake, padding, AES rounds and digest output.
module amh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              has_byte,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              word_sel,
  input  amh_pkg::amh_sts_t sts,
  output amh_pkg::amh_cmd_t cmd
);
  import amh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ROUND, S_CHAIN, S_PAD, S_PAD_X, S_LEN, S_OUT0, S_OUT1
  } state_t;

  state_t          st;
  logic            fin;      // message end pending after current block
  logic            final_blk;// block in AES is the length block
  logic            pad_tail; // block in AES is the extra padding block
  logic [ROUND_W-1:0] cnt;

  assign in_ready  = (st == S_IDLE);
  assign out_valid = (st == S_OUT0) || (st == S_OUT1);
  assign word_sel  = (st == S_OUT1);

  always_comb begin
    cmd = '0;
    unique case (st)
      S_IDLE:  cmd.put_byte = in_valid && has_byte;
      S_START: cmd.aes_start = 1'b1;
      S_ROUND: cmd.aes_round = 1'b1;
      S_CHAIN: cmd.chain_update = 1'b1;
      S_PAD:   cmd.pad = 1'b1;
      S_PAD_X: cmd.put_len = 1'b1;
      S_LEN:   cmd.put_len = 1'b1;
      S_OUT1:  cmd.clear_all = out_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      fin       <= 1'b0;
      final_blk <= 1'b0;
      cnt       <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            fin <= last;
            if (has_byte && sts.block_full) begin
              final_blk <= 1'b0;
              st <= S_START;
            end else if (last) begin
              st <= S_PAD;
            end
          end
        end
        S_START: begin
          cnt <= '0;
          st  <= S_ROUND;
        end
        S_ROUND: begin
          cnt <= cnt + 4'd1;
          if (cnt == ROUND_W'(NUM_ROUNDS - 1)) st <= S_CHAIN;
        end
        S_CHAIN: begin
          // After an extra padding block, the cleared block takes only the length.
          if (final_blk) st <= S_OUT0;
          else if (pad_tail) st <= S_LEN;
          else if (fin) st <= S_PAD;
          else st <= S_IDLE;
        end
        S_PAD: begin
          // With 14+ held padding overwrites length bytes; extra block compressed at 13+.
          if (sts.pad_extra) begin
            final_blk <= 1'b0;
            fin       <= 1'b0;
            st        <= S_START;
          end else begin
            st <= S_LEN;
          end
        end
        S_PAD_X: st <= S_START;
        S_LEN: begin
          final_blk <= 1'b1;
          st        <= S_START;
        end
        S_OUT0: if (out_ready) st <= S_OUT1;
        S_OUT1: begin
          if (out_ready) begin
            fin       <= 1'b0;
            final_blk <= 1'b0;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Mark that the block now in AES is the extra padding block.
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_tail <= 1'b0;
    end else if (st == S_PAD && sts.pad_extra) begin
      pad_tail <= 1'b1;
    end else if (st == S_CHAIN) begin
      pad_tail <= 1'b0;
    end
  end

endmodule

[hdl/aes_mmo_hash_unit.sv]
// Top level: AES-128 Matyas-Meyer-Oseas hash over a byte stream.
//
//  channel  dir  payload                         transaction
//  in_ch    in   data_byte[8] has_byte last      one message byte or end mark
//  out_ch   out  digest_word[64] word_last       one half of the digest
//
// A byte that does not complete a block is taken into the buffer. A block
// completion runs the round-iterative AES core: a load step, ten rounds and
// a chain update. An end mark adds padding and one or two such compressions,
// then two output transactions. Synchronous reset returns the chain, buffer
// and length to zero. A stalled output holds the digest and blocks input
// until both words are taken.
module aes_mmo_hash_unit (
  input logic clk,
  input logic rst,
  amh_if.sink   in_ch,
  amh_if.source out_ch
);
  import amh_pkg::*;

  amh_cmd_t cmd;
  amh_sts_t sts;
  blk_t     chain;
  logic     word_sel;

  amh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .has_byte (in_ch.payload.has_byte),
    .last     (in_ch.payload.last),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .word_sel (word_sel),
    .sts      (sts),
    .cmd      (cmd)
  );

  amh_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .data_byte(in_ch.payload.data_byte),
    .sts      (sts),
    .chain    (chain)
  );

  // Select the digest half: bytes 0-7 first.
  assign out_ch.payload.digest_word = word_sel ? chain[63:0] : chain[127:64];
  assign out_ch.payload.word_last   = word_sel;

endmodule
